// ----- hdl/ntg_pkg.sv -----
package ntg_pkg;

	// Default tick rate of the time base, in ticks per second.
	localparam int unsigned TIME_BASE_DEF = 100000;

	// Field and state widths.
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned LEN_W   = 2;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned FREQ_W  = 11;
	localparam int unsigned MULT_W  = 3;
	localparam int unsigned CYC_W   = 14;
	localparam int unsigned HALF_W  = 8;
	localparam int unsigned PHASE_W = 8;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned NOTES   = 12;

	// Command codes carried on the input side.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Register indexes.
	localparam logic REG_TEMPO = 1'b0;
	localparam logic REG_PITCH = 1'b1;

	// Tempo and pitch codes.
	localparam logic [MODE_W-1:0] TEMPO_X1   = 2'd0;
	localparam logic [MODE_W-1:0] TEMPO_X2   = 2'd1;
	localparam logic [MODE_W-1:0] TEMPO_HALF = 2'd2;
	localparam logic [MODE_W-1:0] PITCH_SAME = 2'd0;
	localparam logic [MODE_W-1:0] PITCH_UP   = 2'd1;
	localparam logic [MODE_W-1:0] PITCH_DOWN = 2'd2;

	// Sequencer states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} ntg_state_t;

	// Base frequency in Hz of each semitone, A at 440 Hz upwards.
	function automatic logic [FREQ_W-1:0] base_hz(input logic [IDX_W-1:0] idx);
		logic [FREQ_W-1:0] f;
		unique case (idx)
			4'd0:    f = 11'd440;
			4'd1:    f = 11'd466;
			4'd2:    f = 11'd493;
			4'd3:    f = 11'd523;
			4'd4:    f = 11'd554;
			4'd5:    f = 11'd587;
			4'd6:    f = 11'd622;
			4'd7:    f = 11'd659;
			4'd8:    f = 11'd698;
			4'd9:    f = 11'd739;
			4'd10:   f = 11'd783;
			default: f = 11'd830;
		endcase
		return f;
	endfunction

endpackage

// ----- hdl/note_tone_generator_unit.sv -----
// Channel   Direction  Handshake           Contents
// s_*       in         s_tvalid/s_tready   tuser cmd, tdata note_index and note_length
// m_*       out        m_tvalid/m_tready   tdata pin_level and busy_res, tlast note_done
// APB       in/out     psel/penable        tempo_mode at 0x0, pitch_mode at 0x4
//
// A tick transaction is handled in the cycle it is accepted and its result is
// registered for the output side; the next item may follow as that result is taken.
// A start transaction keeps the input side stalled after it is accepted, while the
// bit-serial divider forms the half period from TIME_BASE, whose bit width is TBW
// (17 bits at the default).
// Reset clears the wave state, both registers and the output slot.
// The input side stalls while the divider runs and while a result waits unclaimed.
module note_tone_generator_unit #(
	parameter int unsigned TIME_BASE = ntg_pkg::TIME_BASE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [3:0] note_index, [5:4] note_length
	input  logic                          s_tuser,   // [0] cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [0] pin_level, [1] busy_res
	output logic                          m_tlast,   // note_done
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ntg_pkg::PADDR_W-1:0]   paddr,
	input  logic [ntg_pkg::PDATA_W-1:0]   pwdata,
	output logic [ntg_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import ntg_pkg::*;

	// Width of the dividend and of the quotient built in its place.
	localparam int unsigned TBW   = $clog2(TIME_BASE + 1);
	localparam int unsigned CNT_W = $clog2(TBW);

	// Configuration registers, sampled by each start transaction.
	logic [MODE_W-1:0] tempo_q, pitch_q;

	// Note state.
	logic               wave_q, playing_q;
	logic [HALF_W-1:0]  half_q;
	logic [PHASE_W-1:0] phase_q;
	logic [CYC_W-1:0]   cycles_q;

	// Divider: the remainder and a shift register that feeds dividend bits out at
	// the top while quotient bits enter at the bottom.
	ntg_state_t         state_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [FREQ_W-1:0]  rem_q;
	logic [TBW-1:0]     dvd_q;
	logic [CNT_W-1:0]   cnt_q;

	// Output slot.
	logic out_valid_q, out_pin_q, out_busy_q, out_done_q;

	logic                wr_en;
	logic                in_acc;
	logic [IDX_W-1:0]    idx_in;
	logic [LEN_W-1:0]    len_in;
	logic [FREQ_W-1:0]   base_f, note_f;
	logic [MULT_W-1:0]   mult;
	logic [CYC_W-1:0]    prod, cyc_new;
	logic [FREQ_W:0]     trial, trial_sub;
	logic                q_bit;
	logic [TBW-1:0]      quot;
	logic [TBW-2:0]      half_full;
	logic [HALF_W-1:0]   half_new;
	logic [PHASE_W-1:0]  phase_inc;
	logic [CYC_W-1:0]    cyc_dec;
	logic                tick_wave, tick_play, tick_done;
	logic [PHASE_W-1:0]  tick_phase;
	logic [CYC_W-1:0]    tick_cyc;

	// APB: always ready; registers decode on the word address only.
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_PITCH) ? PDATA_W'(pitch_q) : PDATA_W'(tempo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= TEMPO_X1;
			pitch_q <= PITCH_SAME;
		end else if (wr_en) begin
			if (paddr[2] == REG_PITCH) begin
				pitch_q <= pwdata[MODE_W-1:0];
			end else begin
				tempo_q <= pwdata[MODE_W-1:0];
			end
		end
	end

	// An item enters only when the divider is idle and the output slot can take
	// its result in the same edge.
	assign s_tready = (state_q == ST_IDLE) & (~out_valid_q | m_tready);
	assign in_acc   = s_tvalid & s_tready;
	assign idx_in   = s_tdata[IDX_W-1:0];
	assign len_in   = s_tdata[IDX_W+LEN_W-1:IDX_W];

	// Start: note frequency after the octave shift, and the cycle count. The
	// duration multiplier counts in halves for the halving tempo, so the product
	// is halved afterwards; unused codes behave as the plain setting.
	always_comb begin
		base_f = base_hz((idx_in > IDX_W'(NOTES - 1)) ? IDX_W'(NOTES - 1) : idx_in);
		unique case (pitch_q)
			PITCH_UP:   note_f = {base_f[FREQ_W-2:0], 1'b0};
			PITCH_DOWN: note_f = {1'b0, base_f[FREQ_W-1:1]};
			default:    note_f = base_f;
		endcase
		unique case (tempo_q)
			TEMPO_X2:   mult = {len_in, 1'b1};
			TEMPO_HALF: mult = MULT_W'(len_in) + MULT_W'(2);
			default:    mult = MULT_W'(len_in) + MULT_W'(1);
		endcase
		prod    = CYC_W'(note_f) * CYC_W'(mult);
		cyc_new = (tempo_q == TEMPO_HALF) ? {1'b0, prod[CYC_W-1:1]} : prod;
	end

	// One restoring-division step per cycle.
	always_comb begin
		trial     = {rem_q, dvd_q[TBW-1]};
		trial_sub = trial - {1'b0, freq_q};
		q_bit     = (trial >= {1'b0, freq_q});
		quot      = {dvd_q[TBW-2:0], q_bit};
		half_full = quot[TBW-1:1];
		// A zero half period is raised to one before the field is cut to width.
		half_new  = (half_full == '0) ? HALF_W'(1) : half_full[HALF_W-1:0];
	end

	// Tick, while a note plays: advance the phase, flip the level at the end of each
	// half period and count a cycle off after each low half; the last one ends the note.
	always_comb begin
		phase_inc  = phase_q + PHASE_W'(1);
		cyc_dec    = cycles_q - CYC_W'(1);
		tick_wave  = wave_q;
		tick_play  = playing_q;
		tick_done  = 1'b0;
		tick_phase = phase_q;
		tick_cyc   = cycles_q;
		if (playing_q) begin
			tick_phase = phase_inc;
			if (phase_inc >= half_q) begin
				tick_phase = '0;
				if (wave_q) begin
					tick_wave = 1'b0;
				end else begin
					tick_cyc = cyc_dec;
					if (cyc_dec == '0) begin
						tick_play = 1'b0;
						tick_done = 1'b1;
					end else begin
						tick_wave = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wave_q    <= 1'b0;
			playing_q <= 1'b0;
			half_q    <= '0;
			phase_q   <= '0;
			cycles_q  <= '0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == CMD_START) begin
							state_q   <= ST_DIV;
							cnt_q     <= '0;
							wave_q    <= 1'b1;
							playing_q <= 1'b1;
							phase_q   <= '0;
							cycles_q  <= cyc_new;
						end else begin
							wave_q    <= tick_wave;
							playing_q <= tick_play;
							phase_q   <= tick_phase;
							cycles_q  <= tick_cyc;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(TBW - 1)) begin
						half_q  <= half_new;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider datapath needs no reset: it is loaded by every start.
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == CMD_START) begin
			freq_q <= note_f;
			rem_q  <= '0;
			dvd_q  <= TBW'(TIME_BASE);
		end else if (state_q == ST_DIV) begin
			rem_q <= q_bit ? trial_sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
			dvd_q <= quot;
		end
	end

	// Output slot: a start always shows a high level, busy and not done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_pin_q   <= 1'b0;
			out_busy_q  <= 1'b0;
			out_done_q  <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
			if (s_tuser == CMD_START) begin
				out_pin_q  <= 1'b1;
				out_busy_q <= 1'b1;
				out_done_q <= 1'b0;
			end else begin
				out_pin_q  <= tick_wave;
				out_busy_q <= tick_play;
				out_done_q <= tick_done;
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_busy_q, out_pin_q};
	assign m_tlast  = out_done_q;

endmodule

// ----- hdl/ntg_checker.sv -----
module ntg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);
	import ntg_pkg::*;

	// Every accepted transaction yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted transaction gave no result");

	// A start always shows a sounding high level that is not done.
	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_START |=> m_tdata[1:0] == 2'b11 && !m_tlast)
		else $error("start result is not high and busy");

	// The tick that ends a note leaves the pin low and the player idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[1:0] == 2'b00)
		else $error("done flagged while the note still sounds");

	// No new transaction while the waiting result is not taken.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted over an unclaimed result");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind note_tone_generator_unit ntg_checker u_ntg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
